[src/gic_pkg.sv]
// shared constants and types of the gamepad input conditioner
package gic_pkg;

  localparam int unsigned NUM_BUTTONS = 14;
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned DZ_W        = 15;

  localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  // per-button tracker phase
  typedef enum logic [1:0] {
    PH_FREE = 2'd0,
    PH_DOWN = 2'd1,
    PH_HELD = 2'd2,
    PH_UP   = 2'd3
  } phase_e;

  // configuration register index
  typedef enum logic [0:0] {
    CFG_LEFT_DZ  = 1'b0,
    CFG_RIGHT_DZ = 1'b1
  } cfg_idx_e;

endpackage

[src/gic_if.sv]
// request and result channel interfaces of the gamepad input conditioner
interface gic_in_if;
  logic                 valid;
  logic                 ready;
  gic_pkg::btn_mask_t   button_mask;
  gic_pkg::axis_t       left_x_raw;
  gic_pkg::axis_t       left_y_raw;
  gic_pkg::axis_t       right_x_raw;
  gic_pkg::axis_t       right_y_raw;

  modport source (output valid, button_mask, left_x_raw, left_y_raw, right_x_raw,
                  right_y_raw, input ready);
  modport sink (input valid, button_mask, left_x_raw, left_y_raw, right_x_raw,
                right_y_raw, output ready);
endinterface

interface gic_out_if;
  logic                 valid;
  logic                 ready;
  gic_pkg::btn_mask_t   held_mask;
  gic_pkg::btn_mask_t   pressed_edge_mask;
  gic_pkg::btn_mask_t   released_edge_mask;
  gic_pkg::axis_t       left_x_norm;
  gic_pkg::axis_t       left_y_norm;
  gic_pkg::axis_t       right_x_norm;
  gic_pkg::axis_t       right_y_norm;

  modport source (output valid, held_mask, pressed_edge_mask, released_edge_mask,
                  left_x_norm, left_y_norm, right_x_norm, right_y_norm, input ready);
  modport sink (input valid, held_mask, pressed_edge_mask, released_edge_mask,
                left_x_norm, left_y_norm, right_x_norm, right_y_norm, output ready);
endinterface

[src/gamepad_input_conditioner.sv]
// gamepad input conditioner top level: button trackers and stick normalization
//
// One request per controller frame. Buttons run a free/down/held/up tracker
// and come out as held, just-pressed and just-released masks. Each stick axis
// goes through a deadzone (values strictly inside become zero, others are
// moved toward zero by the deadzone) and is scaled to Q1.15 by 32768 or 32767
// minus the deadzone; a stick vector longer than one is divided by its length.
// Q1.15 values truncate toward zero and saturate at 32767. All stick math
// runs on one shared 32x32 multiplier plus one shared shift/subtract unit
// that does either a restoring divide or a bit-serial ratio-over-root search,
// 16 steps per axis. Per stick a request passes a deadzone state, the
// multiplier products p, q, da*db and their squares, a compare state and
// for each axis a load, 16 search steps and a store; a final state then
// hands over the result, and waits there while the output register is
// still full and not taken. No new request is taken until the last is
// through: in_i.ready is high only while the block is idle; a finished
// result waits in the output register while the next request is taken.
// Deadzone writes are expected only while the block is idle.
module gamepad_input_conditioner (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  gic_pkg::cfg_idx_e       cfg_idx_i,
  input  logic [gic_pkg::DZ_W-1:0] cfg_data_i,
  gic_in_if.sink                  in_i,
  gic_out_if.source               out_o
);
  import gic_pkg::*;

  localparam int unsigned W = 94;  // search unit width: root search needs 93 bits

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DEAD  = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_CMP   = 8'b0000_1000,
    ST_LOAD  = 8'b0001_0000,
    ST_ITER  = 8'b0010_0000,
    ST_STORE = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
    logic [16:0] den;
  } dead_t;

  // deadzone, shift toward zero and scale denominator of one axis
  function automatic dead_t dead_axis(input axis_t v, input logic [DZ_W-1:0] dz);
    logic signed [17:0] vs;
    logic signed [17:0] ds;
    logic signed [17:0] a;
    logic signed [17:0] den;
    dead_t r;
    vs = 18'(v);
    ds = signed'({3'b000, dz});
    if ((vs < ds) && (vs > -ds)) a = '0;
    else if (vs < 0)             a = vs + ds;
    else                         a = vs - ds;
    den = ((a < 0) ? 18'sd32768 : 18'sd32767) - ds;
    if (den == 0) a = '0;
    r.neg = (a < 0);
    r.mag = (a < 0) ? 16'(-a) : 16'(a);
    r.den = 17'(den);
    return r;
  endfunction

  // q1.15 with saturation at +32767 and -32768
  function automatic axis_t to_q15(input logic neg, input logic [15:0] mag);
    logic [15:0] m;
    m = mag;
    if (!neg && (m > 16'd32767)) m = 16'd32767;
    if (m > 16'd32768) m = 16'd32768;
    return neg ? axis_t'(-m) : axis_t'(m);
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [DZ_W-1:0] left_dz_q, right_dz_q;

  // request and button tracking
  phase_e    phase_q [NUM_BUTTONS];
  btn_mask_t held_q, pr_q, rel_q;
  axis_t     lx_q, ly_q, rx_q, ry_q;

  // per stick operands
  logic        stick_q, axis_q;
  logic [15:0] ua_q, ub_q;
  logic [16:0] da_q, db_q;
  logic        na_q, nb_q;
  logic [2:0]  mul_cnt_q;
  logic [31:0] p_q, q_q, m_q;
  logic [61:0] pp_q, qq_q, ll_q;
  logic [62:0] s_q;
  logic        clip_q;

  // shared divide / root search unit
  logic [W-1:0] r_q, ts_q, ss_q;
  logic [15:0]  k_q;
  logic [3:0]   bit_cnt_q;
  logic         root_q, zero_q;

  // stick results and output register
  axis_t lxn_q, lyn_q, rxn_q, ryn_q;
  logic  out_valid_q;

  logic        in_acc;
  axis_t       cur_x, cur_y;
  logic [DZ_W-1:0] cur_dz;
  dead_t       dx, dy;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [W-1:0] d_sum;
  logic        take;
  axis_t       q15_res;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign cur_x  = stick_q ? rx_q : lx_q;
  assign cur_y  = stick_q ? ry_q : ly_q;
  assign cur_dz = stick_q ? right_dz_q : left_dz_q;
  assign dx     = dead_axis(cur_x, cur_dz);
  assign dy     = dead_axis(cur_y, cur_dz);

  // shared multiplier operand select
  always_comb begin
    unique case (mul_cnt_q)
      3'd0:    begin mul_a = {16'd0, ua_q};  mul_b = {15'd0, db_q}; end
      3'd1:    begin mul_a = {16'd0, ub_q};  mul_b = {15'd0, da_q}; end
      3'd2:    begin mul_a = {15'd0, da_q};  mul_b = {15'd0, db_q}; end
      3'd3:    begin mul_a = p_q;            mul_b = p_q;           end
      3'd4:    begin mul_a = q_q;            mul_b = q_q;           end
      default: begin mul_a = m_q;            mul_b = m_q;           end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one trial step: subtract the candidate increment if it fits
  assign d_sum   = ts_q + ss_q;
  assign take    = (r_q >= d_sum);
  assign q15_res = to_q15(axis_q ? nb_q : na_q, zero_q ? 16'd0 : k_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_DEAD;
      ST_DEAD:  state_d = ST_MUL;
      ST_MUL:   if (mul_cnt_q == 3'd5) state_d = ST_CMP;
      ST_CMP:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_ITER;
      ST_ITER:  if (bit_cnt_q == 4'd0) state_d = ST_STORE;
      ST_STORE: begin
        if (!axis_q)      state_d = ST_LOAD;
        else if (!stick_q) state_d = ST_DEAD;
        else              state_d = ST_FIN;
      end
      ST_FIN:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_dz_q   <= LEFT_DZ_RST;
      right_dz_q  <= RIGHT_DZ_RST;
      out_valid_q <= 1'b0;
      stick_q     <= 1'b0;
      axis_q      <= 1'b0;
      mul_cnt_q   <= '0;
      bit_cnt_q   <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) phase_q[i] <= PH_FREE;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
          CFG_RIGHT_DZ: right_dz_q <= cfg_data_i;
          default:      left_dz_q  <= left_dz_q;
        endcase
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            stick_q <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              if (in_i.button_mask[i])
                phase_q[i] <= (phase_q[i] == PH_FREE || phase_q[i] == PH_UP) ?
                              PH_DOWN : PH_HELD;
              else
                phase_q[i] <= (phase_q[i] == PH_DOWN || phase_q[i] == PH_HELD) ?
                              PH_UP : PH_FREE;
            end
          end
        end
        ST_DEAD:  mul_cnt_q <= '0;
        ST_MUL:   mul_cnt_q <= mul_cnt_q + 3'd1;
        ST_CMP:   axis_q <= 1'b0;
        ST_LOAD:  bit_cnt_q <= 4'd15;
        ST_ITER:  bit_cnt_q <= bit_cnt_q - 4'd1;
        ST_STORE: begin
          if (!axis_q) axis_q <= 1'b1;
          else         stick_q <= 1'b1;
        end
        ST_FIN:   if (!out_valid_q || out_o.ready) out_valid_q <= 1'b1;
        default:  ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lx_q <= in_i.left_x_raw;
          ly_q <= in_i.left_y_raw;
          rx_q <= in_i.right_x_raw;
          ry_q <= in_i.right_y_raw;
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            held_q[i] <= in_i.button_mask[i] &&
                         (phase_q[i] == PH_DOWN || phase_q[i] == PH_HELD);
            pr_q[i]   <= in_i.button_mask[i] &&
                         (phase_q[i] == PH_FREE || phase_q[i] == PH_UP);
            rel_q[i]  <= !in_i.button_mask[i] &&
                         (phase_q[i] == PH_DOWN || phase_q[i] == PH_HELD);
          end
        end
      end
      ST_DEAD: begin
        ua_q <= dx.mag;  da_q <= dx.den;  na_q <= dx.neg;
        ub_q <= dy.mag;  db_q <= dy.den;  nb_q <= dy.neg;
      end
      ST_MUL: begin
        unique case (mul_cnt_q)
          3'd0:    p_q  <= mul_p[31:0];
          3'd1:    q_q  <= mul_p[31:0];
          3'd2:    m_q  <= mul_p[31:0];
          3'd3:    pp_q <= mul_p[61:0];
          3'd4:    qq_q <= mul_p[61:0];
          default: ll_q <= mul_p[61:0];
        endcase
      end
      ST_CMP: begin
        // vector longer than one when p^2 + q^2 exceeds (da*db)^2
        s_q    <= {1'b0, pp_q} + {1'b0, qq_q};
        clip_q <= (({1'b0, pp_q} + {1'b0, qq_q}) > {1'b0, ll_q});
      end
      ST_LOAD: begin
        ts_q <= '0;
        k_q  <= '0;
        if (clip_q) begin
          // largest k with k^2 * s <= p^2 * 2^30 (q^2 for the y axis)
          root_q <= 1'b1;
          zero_q <= 1'b0;
          r_q    <= {2'b00, (axis_q ? qq_q : pp_q), 30'd0};
          ss_q   <= {1'b0, s_q, 30'd0};
        end else begin
          // restoring divide of mag * 2^15 by den
          root_q <= 1'b0;
          zero_q <= ((axis_q ? db_q : da_q) == 17'd0);
          r_q    <= {63'd0, (axis_q ? ub_q : ua_q), 15'd0};
          ss_q   <= {62'd0, (axis_q ? db_q : da_q), 15'd0};
        end
      end
      ST_ITER: begin
        k_q <= {k_q[14:0], take};
        if (take) r_q <= r_q - d_sum;
        if (root_q) begin
          ts_q <= take ? ((ts_q >> 1) + ss_q) : (ts_q >> 1);
          ss_q <= ss_q >> 2;
        end else begin
          ss_q <= ss_q >> 1;
        end
      end
      ST_STORE: begin
        priority case ({stick_q, axis_q})
          2'b00:   lxn_q <= q15_res;
          2'b01:   lyn_q <= q15_res;
          2'b10:   rxn_q <= q15_res;
          default: ryn_q <= q15_res;
        endcase
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_o.held_mask          <= held_q;
          out_o.pressed_edge_mask  <= pr_q;
          out_o.released_edge_mask <= rel_q;
          out_o.left_x_norm        <= lxn_q;
          out_o.left_y_norm        <= lyn_q;
          out_o.right_x_norm       <= rxn_q;
          out_o.right_y_norm       <= ryn_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;

endmodule
